### design/rdsd_pkg.sv
// ----------------------------------------------------------------------------
// rdsd_pkg
// Shared types and constants of the relocation delta stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rdsd_pkg;

  localparam int unsigned WordW = 64;

  // request kinds
  localparam logic ReqWord = 1'b0;
  localparam logic ReqTick = 1'b1;

  // result status codes
  localparam logic StatRecord = 1'b0;
  localparam logic StatError  = 1'b1;

  typedef enum logic [8:0] {
    PhTotal    = 9'b000000001,
    PhFirstOff = 9'b000000010,
    PhGroupCnt = 9'b000000100,
    PhInfo     = 9'b000001000,
    PhFirstAdd = 9'b000010000,
    PhDelta    = 9'b000100000,
    PhRunCnt   = 9'b001000000,
    PhRunAdd   = 9'b010000000,
    PhRunTick  = 9'b100000000
  } phase_e;

  typedef struct packed {
    logic             req_type;
    logic [WordW-1:0] packed_word;
  } item_t;

  typedef struct packed {
    logic                    status;
    logic [WordW-1:0]        rel_offset;
    logic [WordW-1:0]        rel_info;
    logic signed [WordW-1:0] rel_addend;
    logic                    addend_in_stream;
    logic                    last_of_table;
  } result_t;

endpackage

`default_nettype wire

### design/rdsd_req_if.sv
// ----------------------------------------------------------------------------
// rdsd_req_if
// Request channel: stream words and ticks with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdsd_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [rdsd_pkg::WordW-1:0]  packed_word;

  modport source (output valid, output req_type, output packed_word, input ready);
  modport sink   (input valid, input req_type, input packed_word, output ready);
endinterface

`default_nettype wire

### design/rdsd_rsp_if.sv
// ----------------------------------------------------------------------------
// rdsd_rsp_if
// Response channel: decoded relocation records and error words.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdsd_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              status;
  logic [rdsd_pkg::WordW-1:0]        rel_offset;
  logic [rdsd_pkg::WordW-1:0]        rel_info;
  logic signed [rdsd_pkg::WordW-1:0] rel_addend;
  logic                              addend_in_stream;
  logic                              last_of_table;

  modport source (output valid, output status, output rel_offset, output rel_info,
                  output rel_addend, output addend_in_stream, output last_of_table,
                  input ready);
  modport sink   (input valid, input status, input rel_offset, input rel_info,
                  input rel_addend, input addend_in_stream, input last_of_table,
                  output ready);
endinterface

`default_nettype wire

### design/rdsd_in_stage.sv
// ----------------------------------------------------------------------------
// rdsd_in_stage
// Input register: holds one accepted item until the decode step takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rdsd_in_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire rdsd_pkg::item_t item_i,
  output logic                 valid_o,
  input  wire logic            take_i,
  output rdsd_pkg::item_t      item_o
);

  logic            valid_d, valid_q;
  rdsd_pkg::item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

### design/rdsd_step.sv
// ----------------------------------------------------------------------------
// rdsd_step
// Decode state and one-word step: parses the group layout, tracks runs and
// counts, and forms at most one record or error per item.
// ----------------------------------------------------------------------------
`default_nettype none

module rdsd_step (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire rdsd_pkg::item_t item_i,
  output logic                 res_valid_o,
  output rdsd_pkg::result_t    res_o
);

  localparam int unsigned W = rdsd_pkg::WordW;

  rdsd_pkg::phase_e phase_d, phase_q;
  logic [W-1:0] records_left_d, records_left_q;
  logic [W-1:0] group_left_d, group_left_q;
  logic [W-1:0] run_left_d, run_left_q;
  logic [W-1:0] offset_d, offset_q;
  logic [W-1:0] delta_d, delta_q;
  logic [W-1:0] info_d, info_q;
  logic         addends_d, addends_q;

  logic         do_emit, do_err;
  logic [W-1:0] rec_addend;
  logic         rec_stream;
  logic [W-1:0] offset_sum;
  logic [W-1:0] word;

  assign word       = item_i.packed_word;
  assign offset_sum = offset_q + delta_q;

  always_comb begin
    phase_d        = phase_q;
    records_left_d = records_left_q;
    group_left_d   = group_left_q;
    run_left_d     = run_left_q;
    offset_d       = offset_q;
    delta_d        = delta_q;
    info_d         = info_q;
    addends_d      = addends_q;
    do_emit        = 1'b0;
    do_err         = 1'b0;
    rec_addend     = '0;
    rec_stream     = 1'b0;

    if (item_i.req_type == rdsd_pkg::ReqTick) begin
      if (phase_q == rdsd_pkg::PhRunTick) begin
        offset_d   = offset_sum;
        run_left_d = run_left_q - W'(1);
        do_emit    = 1'b1;
      end
    end else begin
      case (phase_q)
        rdsd_pkg::PhFirstOff: begin
          offset_d   = {word[W-1:2], 2'b00};
          addends_d  = word[1];
          run_left_d = '0;
          if (word[0]) begin
            group_left_d = W'(1);
            phase_d      = rdsd_pkg::PhInfo;
          end else begin
            phase_d = rdsd_pkg::PhGroupCnt;
          end
        end
        rdsd_pkg::PhGroupCnt: begin
          group_left_d = word;
          phase_d      = rdsd_pkg::PhInfo;
        end
        rdsd_pkg::PhInfo: begin
          info_d = word;
          if (addends_q) begin
            phase_d = rdsd_pkg::PhFirstAdd;
          end else begin
            do_emit = 1'b1;
          end
        end
        rdsd_pkg::PhFirstAdd: begin
          do_emit    = 1'b1;
          rec_addend = word;
          rec_stream = 1'b1;
        end
        rdsd_pkg::PhDelta: begin
          delta_d    = {word[W-1:2], 2'b00};
          run_left_d = W'(word[1:0]);
          if (word[1:0] == 2'b00) begin
            phase_d = rdsd_pkg::PhRunCnt;
          end else begin
            phase_d = addends_q ? rdsd_pkg::PhRunAdd : rdsd_pkg::PhRunTick;
          end
        end
        rdsd_pkg::PhRunCnt: begin
          run_left_d = word;
          if (word == '0) begin
            phase_d = rdsd_pkg::PhDelta;
          end else begin
            phase_d = addends_q ? rdsd_pkg::PhRunAdd : rdsd_pkg::PhRunTick;
          end
        end
        rdsd_pkg::PhRunAdd: begin
          offset_d   = offset_sum;
          run_left_d = run_left_q - W'(1);
          do_emit    = 1'b1;
          rec_addend = word;
          rec_stream = 1'b1;
        end
        rdsd_pkg::PhRunTick: begin
          // word mid-run: report and drop, state untouched
          do_err = 1'b1;
        end
        default: begin
          records_left_d = word;
          group_left_d   = '0;
          run_left_d     = '0;
          phase_d        = (word != '0) ? rdsd_pkg::PhFirstOff : rdsd_pkg::PhTotal;
        end
      endcase
    end

    // count down on each record and close the run, group or table
    if (do_emit) begin
      if (records_left_q != '0) records_left_d = records_left_q - W'(1);
      if (group_left_q != '0)   group_left_d   = group_left_q - W'(1);
      if (run_left_d == '0) begin
        if (group_left_d != '0) begin
          phase_d = rdsd_pkg::PhDelta;
        end else if (records_left_d != '0) begin
          phase_d = rdsd_pkg::PhFirstOff;
        end else begin
          phase_d = rdsd_pkg::PhTotal;
        end
      end
    end
  end

  always_comb begin
    res_valid_o = do_emit || do_err;
    res_o       = '0;
    if (do_err) begin
      res_o.status = rdsd_pkg::StatError;
    end else begin
      res_o.status           = rdsd_pkg::StatRecord;
      res_o.rel_offset       = offset_d;
      res_o.rel_info         = info_d;
      res_o.rel_addend       = rec_addend;
      res_o.addend_in_stream = rec_stream;
      res_o.last_of_table    = (records_left_q == W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= rdsd_pkg::PhTotal;
      records_left_q <= '0;
      group_left_q   <= '0;
      run_left_q     <= '0;
      offset_q       <= '0;
      delta_q        <= '0;
      info_q         <= '0;
      addends_q      <= 1'b0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      records_left_q <= records_left_d;
      group_left_q   <= group_left_d;
      run_left_q     <= run_left_d;
      offset_q       <= offset_d;
      delta_q        <= delta_d;
      info_q         <= info_d;
      addends_q      <= addends_d;
    end
  end

  a_err_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && do_err) |=> (phase_q == rdsd_pkg::PhRunTick) && $stable(run_left_q)
                           && $stable(offset_q) && $stable(records_left_q))
    else $error("error word changed decode state");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(records_left_q) && $stable(offset_q))
    else $error("decode state moved without a step");

  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && do_emit && res_o.last_of_table) |=> (records_left_q == '0))
    else $error("last record left a nonzero remaining count");

  a_offset_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && do_emit) |-> (res_o.rel_offset[1:0] == 2'b00))
    else $error("record offset not word aligned");

endmodule

`default_nettype wire

### design/rdsd_out_stage.sv
// ----------------------------------------------------------------------------
// rdsd_out_stage
// Result register: holds a finished record or error until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rdsd_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire rdsd_pkg::result_t res_i,
  output logic                   free_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output rdsd_pkg::result_t      res_o
);

  logic              valid_d, valid_q;
  rdsd_pkg::result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

### design/relocation_delta_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// relocation_delta_stream_decoder_core
// Rebuilds relocation records from a packed delta stream.
//
// req_i carries stream words (req_type 0) and ticks (req_type 1). Each tick
// releases one record of a run without stream addends; a word sent while
// such a run is open comes back as one error result and is dropped.
// rsp_o carries one record or error per item that causes one; items that
// only update the decode state give no result.
// An item waits in the input register and its result in the result register.
// Throughput: one item per cycle while rsp_o does not stall, as the offset
// adder and the count registers close their loop on every step.
// An input register and a result register part the two channels, so one new
// item is taken while a result waits; a stall on rsp_o holds the result and
// backs up into req_i after one more item.
// Reset empties both registers and puts the decoder back to waiting for a
// total count word.
// ----------------------------------------------------------------------------
`default_nettype none

module relocation_delta_stream_decoder_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rdsd_req_if.sink   req_i,
  rdsd_rsp_if.source rsp_o
);

  rdsd_pkg::item_t   in_item, s1_item;
  rdsd_pkg::result_t step_res, out_res;
  logic              s1_valid, step_en, res_valid, out_free, out_valid;

  assign in_item.req_type    = req_i.req_type;
  assign in_item.packed_word = req_i.packed_word;

  rdsd_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_i.valid),
    .ready_o (req_i.ready),
    .item_i  (in_item),
    .valid_o (s1_valid),
    .take_i  (step_en),
    .item_o  (s1_item)
  );

  // advance only when the result register can take whatever comes out
  assign step_en = s1_valid && out_free;

  rdsd_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step_en),
    .item_i      (s1_item),
    .res_valid_o (res_valid),
    .res_o       (step_res)
  );

  rdsd_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step_en && res_valid),
    .res_i   (step_res),
    .free_o  (out_free),
    .valid_o (out_valid),
    .ready_i (rsp_o.ready),
    .res_o   (out_res)
  );

  assign rsp_o.valid            = out_valid;
  assign rsp_o.status           = out_res.status;
  assign rsp_o.rel_offset       = out_res.rel_offset;
  assign rsp_o.rel_info         = out_res.rel_info;
  assign rsp_o.rel_addend       = out_res.rel_addend;
  assign rsp_o.addend_in_stream = out_res.addend_in_stream;
  assign rsp_o.last_of_table    = out_res.last_of_table;

endmodule

`default_nettype wire
